// File: sv/rcp_pkg.sv
package rcp_pkg;

  // operand and result widths
  localparam int IN_W   = 32;
  localparam int OUT_W  = 31;

  // seed table: entry i = floor(2^24 / (256 + i)), 257 entries
  localparam int ROM_DEPTH = 257;
  localparam int ROM_AW    = 9;
  localparam int ENTRY_W   = 17;
  localparam int ROM_NUM   = 16777216;
  localparam int ROM_BASE  = 256;

  // fraction split of the normalized mantissa
  localparam int IDX_W = 8;
  localparam int REM_W = 8;

  // signed exponent, covers -16..15
  localparam int EXP_W = 6;
  localparam int POS_W = 5;

  localparam logic [OUT_W-1:0] SAT_MAX = {OUT_W{1'b1}};

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

// File: sv/rcp_rom.sv
module rcp_rom (
  input  logic                       clk,
  input  logic [rcp_pkg::IDX_W-1:0]  rd_idx,
  output rcp_pkg::entry_t            a0_r,
  output rcp_pkg::entry_t            a1_r
);
  import rcp_pkg::*;

  entry_t            rom_w [ROM_DEPTH];
  logic [ROM_AW-1:0] addr0;
  logic [ROM_AW-1:0] addr1;

  // constant seed entries
  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    localparam int Q = ROM_NUM / (ROM_BASE + i);
    assign rom_w[i] = ENTRY_W'(Q);
  end

  assign addr0 = {1'b0, rd_idx};
  assign addr1 = {1'b0, rd_idx} + ROM_AW'(1);

  always_ff @(posedge clk) begin
    a0_r <= rom_w[addr0];
    a1_r <= rom_w[addr1];
  end

endmodule

// File: sv/reciprocal_approx_q16.sv
// throughput: one word per cycle, busy is always low and start may be high every cycle
// seven register stages: magnitude, byte leading-one, position, normalize, table read,
// interpolate, denormalize and saturate
// reset (rst_n low, synchronous) clears the stage valid bits only
// the receiver cannot stall: each result is on the out_ ports for exactly one cycle
module reciprocal_approx_q16 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rcp_pkg::IN_W-1:0]   in_value,
  output logic                              out_valid,
  output logic [rcp_pkg::OUT_W-1:0]         out_reciprocal
);
  import rcp_pkg::*;

  localparam int NBYTE = IN_W / 8;

  // stage valid bits, one per register stage
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_g_r;

  // stage a: magnitude (most negative operand wraps to 2^31, as intended)
  logic [IN_W-1:0] mag_a_r, mag_a_nxt;

  // stage b: per-byte leading-one search
  logic [IN_W-1:0]  mag_b_r;
  logic [NBYTE-1:0] nz_b_r, nz_b_nxt;
  logic [2:0]       pos_b_r [NBYTE];
  logic [2:0]       pos_b_nxt [NBYTE];

  // stage c: leading-one position of the whole word
  logic [IN_W-1:0]  mag_c_r;
  logic [POS_W-1:0] p_c_r, p_c_nxt;
  logic             zero_c_r, zero_c_nxt;

  // stage d: normalized fraction and exponent
  logic [IDX_W-1:0]        idx_d_r;
  logic [REM_W-1:0]        rem_d_r;
  logic signed [EXP_W-1:0] exp_d_r;
  logic                    zero_d_r;
  logic [IN_W-1:0]         norm_d;
  logic [POS_W-1:0]        sh_d;

  // stage e: table entries come back registered from the rom
  entry_t                  a0_e, a1_e;
  logic [REM_W-1:0]        rem_e_r;
  logic signed [EXP_W-1:0] exp_e_r;
  logic                    zero_e_r;

  // stage f: interpolated mantissa
  entry_t                  r_f_r, r_f_nxt;
  logic signed [EXP_W-1:0] exp_f_r;
  logic                    zero_f_r;
  logic [ENTRY_W-1:0]      diff_f;
  logic [ENTRY_W-1:0]      prod_f;
  logic [ENTRY_W-1:0]      dec_f;

  // stage g: output word
  logic [OUT_W-1:0] out_r, out_nxt;
  logic [OUT_W+1:0] wide_g;
  logic [EXP_W-1:0] nexp_g;

  assign busy = 1'b0;

  // control: valid bits march down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_g_r <= 1'b0;
    end else begin
      v_a_r <= start & ~busy;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
      v_f_r <= v_e_r;
      v_g_r <= v_f_r;
    end
  end

  // stage a
  assign mag_a_nxt = in_value[IN_W-1] ? (IN_W'(0) - IN_W'(in_value)) : IN_W'(in_value);

  // stage b: eight-step priority search inside each byte, bytes independent
  always_comb begin
    for (int g = 0; g < NBYTE; g++) begin
      nz_b_nxt[g]  = |mag_a_r[8*g +: 8];
      pos_b_nxt[g] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (mag_a_r[8*g + k]) begin
          pos_b_nxt[g] = 3'(k);
        end
      end
    end
  end

  // stage c: pick the highest nonzero byte
  always_comb begin
    p_c_nxt    = '0;
    zero_c_nxt = ~|nz_b_r;
    for (int g = 0; g < NBYTE; g++) begin
      if (nz_b_r[g]) begin
        p_c_nxt = {2'(g), pos_b_r[g]};
      end
    end
  end

  // stage d: move the leading one to the top bit; fraction sits just below it
  assign sh_d   = ~p_c_r;
  assign norm_d = mag_c_r << sh_d;

  // stage f: floor interpolation, a1 <= a0 so the step is a rounded-up decrement
  assign diff_f  = a0_e - a1_e;
  assign prod_f  = diff_f * ENTRY_W'(rem_e_r);
  assign dec_f   = (prod_f + ENTRY_W'(255)) >> 8;
  assign r_f_nxt = a0_e - dec_f;

  // stage g: undo the normalization and clamp
  assign nexp_g = EXP_W'(0) - EXP_W'(exp_f_r);
  always_comb begin
    wide_g = '0;
    if (exp_f_r >= 0) begin
      wide_g = (OUT_W+2)'(r_f_r) >> exp_f_r[EXP_W-2:0];
    end else begin
      wide_g = (OUT_W+2)'(r_f_r) << nexp_g;
    end
    if (zero_f_r || (|wide_g[OUT_W+1:OUT_W])) begin
      out_nxt = SAT_MAX;
    end else begin
      out_nxt = wide_g[OUT_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_a_r  <= mag_a_nxt;
    mag_b_r  <= mag_a_r;
    nz_b_r   <= nz_b_nxt;
    pos_b_r  <= pos_b_nxt;
    mag_c_r  <= mag_b_r;
    p_c_r    <= p_c_nxt;
    zero_c_r <= zero_c_nxt;
    idx_d_r  <= norm_d[IN_W-2 -: IDX_W];
    rem_d_r  <= norm_d[IN_W-2-IDX_W -: REM_W];
    exp_d_r  <= EXP_W'({1'b0, p_c_r}) - EXP_W'(16);
    zero_d_r <= zero_c_r;
    rem_e_r  <= rem_d_r;
    exp_e_r  <= exp_d_r;
    zero_e_r <= zero_d_r;
    r_f_r    <= r_f_nxt;
    exp_f_r  <= exp_e_r;
    zero_f_r <= zero_e_r;
    out_r    <= out_nxt;
  end

  // seed table, read at idx and idx + 1
  rcp_rom u_rom (
    .clk    (clk),
    .rd_idx (idx_d_r),
    .a0_r   (a0_e),
    .a1_r   (a1_e)
  );

  assign out_valid      = v_g_r;
  assign out_reciprocal = out_r;

  // every result traces back to an earlier start
  a_out_has_start : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 7))
    else $error("result word without a matching start");

  // an accepted word always comes out of the pipe
  a_start_gives_out : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##7 out_valid)
    else $error("accepted word lost in the pipe");

  // zero operand saturates
  a_zero_sat : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_value == 0) |-> ##7 (out_reciprocal == SAT_MAX))
    else $error("zero operand did not saturate");

  // smallest result is 2 (operand 2^31), so a valid word is never zero
  a_out_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reciprocal != '0))
    else $error("zero reciprocal");

  // leading-one position really points at a set bit
  a_lead_one : assert property (@(posedge clk) disable iff (!rst_n)
    (v_c_r && !zero_c_r) |-> (mag_c_r[p_c_r] && ((mag_c_r >> p_c_r) == IN_W'(1))))
    else $error("leading-one search wrong");

endmodule
